FILE: sv/lcdw_pkg.sv
// lcdw_pkg: shared types, constants and tables for the character lcd nibble writer
// no dependencies
`default_nettype none

package lcdw_pkg;

   // operation codes carried in a request
   typedef enum logic [1:0] {
      CMD_INSTR  = 2'd0,
      CMD_DATA   = 2'd1,
      CMD_CURSOR = 2'd2,
      CMD_INIT   = 2'd3
   } command_type;

   // pin-state steps of one byte write
   localparam logic [2:0] STEP_RS       = 3'd0;
   localparam logic [2:0] STEP_E_HIGH1  = 3'd1;
   localparam logic [2:0] STEP_NIB_HIGH = 3'd2;
   localparam logic [2:0] STEP_E_LOW1   = 3'd3;
   localparam logic [2:0] STEP_E_HIGH2  = 3'd4;
   localparam logic [2:0] STEP_NIB_LOW  = 3'd5;
   localparam logic [2:0] STEP_E_LOW2   = 3'd6;

   // hold times in milliseconds
   localparam logic [4:0] HOLD_STEP_MS = 5'd1;
   localparam logic [4:0] HOLD_IDLE_MS = 5'd20;

   // power-up sequence
   localparam int unsigned INIT_BYTE_COUNT = 5;
   localparam logic [2:0]  INIT_LAST_IDX   = 3'(INIT_BYTE_COUNT - 1);

   localparam logic [7:0] CURSOR_CMD_BIT = 8'h80;

   // default depth of the job queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // one classified job: which byte to send and how
   typedef struct packed {
      logic       rs;
      logic [7:0] value;
      logic       is_init;
   } job_type;

   // head of the job queue as seen by the back end
   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_head_type;

   function automatic logic [7:0] init_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = 8'h33;
         3'd1:    b = 8'h32;
         3'd2:    b = 8'h28;
         3'd3:    b = 8'h0C;
         3'd4:    b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] row_offset(input logic [1:0] row);
      logic [7:0] o;
      unique case (row)
         2'd0: o = 8'h00;
         2'd1: o = 8'h40;
         2'd2: o = 8'h10;
         2'd3: o = 8'h50;
      endcase
      return o;
   endfunction

endpackage

`default_nettype wire

FILE: sv/lcdw_front.sv
// lcdw_front: accepts requests, turns them into jobs and queues them
// depends on lcdw_pkg
`default_nettype none

module lcdw_front
   import lcdw_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic [1:0]     req_command,
   input  wire logic [7:0]     req_byte_value,
   input  wire logic [1:0]     req_row,
   input  wire logic [3:0]     req_column,
   output queue_head_type      head,
   input  wire logic           pop
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   job_type          new_job;
   logic             push;
   logic             do_pop;

   // classify the request into rs level, byte and init flag
   always_comb begin
      new_job = '0;
      unique case (command_type'(req_command))
         CMD_INSTR: begin
            new_job.rs    = 1'b0;
            new_job.value = req_byte_value;
         end
         CMD_DATA: begin
            new_job.rs    = 1'b1;
            new_job.value = req_byte_value;
         end
         CMD_CURSOR: begin
            new_job.rs    = 1'b0;
            new_job.value = CURSOR_CMD_BIT | (row_offset(req_row) + {4'd0, req_column});
         end
         CMD_INIT: begin
            new_job.is_init = 1'b1;
         end
      endcase
   end

   // queue handshake
   assign req_stall = (count_ff == FULL_CNT);
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.job   = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

`default_nettype wire

FILE: sv/lcdw_back.sv
// lcdw_back: steps through the pin states of each job and registers the output
// depends on lcdw_pkg
`default_nettype none

module lcdw_back
   import lcdw_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_head_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic                rsp_reg_select,
   output logic                rsp_enable_line,
   output logic [3:0]          rsp_data_nibble,
   output logic [4:0]          rsp_hold_ms,
   output logic                rsp_last_step
);

   // sequencer state
   logic       busy_ff, busy_in;
   logic       idle_ff, idle_in;
   logic [2:0] step_ff, step_in;
   logic [2:0] idx_ff, idx_in;
   job_type    job_ff, job_in;

   // display line levels
   logic       rs_ff, rs_in;
   logic       e_ff, e_in;
   logic [3:0] nib_ff, nib_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic       out_rs_ff, out_rs_in;
   logic       out_e_ff, out_e_in;
   logic [3:0] out_nib_ff, out_nib_in;
   logic [4:0] out_hold_ff, out_hold_in;
   logic       out_last_ff, out_last_in;

   logic       advance;
   logic       fire;
   job_type    cur_job;
   logic       cur_idle;
   logic [2:0] cur_step;
   logic [2:0] cur_idx;
   logic [7:0] cur_byte;
   logic       cur_rs;
   logic       is_last;

   assign advance = !out_valid_ff || !rsp_stall;
   assign fire    = advance && (busy_ff || head.valid);
   assign pop     = advance && !busy_ff && head.valid;

   // a fresh job starts straight from the queue head
   assign cur_job  = busy_ff ? job_ff  : head.job;
   assign cur_idle = busy_ff ? idle_ff : head.job.is_init;
   assign cur_step = busy_ff ? step_ff : STEP_RS;
   assign cur_idx  = busy_ff ? idx_ff  : 3'd0;
   assign cur_byte = cur_job.is_init ? init_byte(cur_idx) : cur_job.value;
   assign cur_rs   = cur_job.is_init ? 1'b0 : cur_job.rs;
   assign is_last  = !cur_idle && (cur_step == STEP_E_LOW2)
                     && (!cur_job.is_init || (cur_idx == INIT_LAST_IDX));

   // next pin state and sequencer advance
   always_comb begin
      busy_in      = busy_ff;
      idle_in      = idle_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      job_in       = job_ff;
      rs_in        = rs_ff;
      e_in         = e_ff;
      nib_in       = nib_ff;
      out_valid_in = out_valid_ff;
      out_rs_in    = out_rs_ff;
      out_e_in     = out_e_ff;
      out_nib_in   = out_nib_ff;
      out_hold_in  = out_hold_ff;
      out_last_in  = out_last_ff;

      if (advance) begin
         out_valid_in = fire;
      end

      if (pop) begin
         job_in = head.job;
      end

      if (fire) begin
         out_last_in = is_last;
         if (cur_idle) begin
            // power-up idle: rs and e low, data lines kept, then cleared
            out_rs_in   = 1'b0;
            out_e_in    = 1'b0;
            out_nib_in  = nib_ff;
            out_hold_in = HOLD_IDLE_MS;
            rs_in       = 1'b0;
            e_in        = 1'b0;
            nib_in      = 4'd0;
            idle_in     = 1'b0;
            step_in     = STEP_RS;
            idx_in      = 3'd0;
            busy_in     = 1'b1;
         end else begin
            unique case (cur_step)
               STEP_RS:       rs_in  = cur_rs;
               STEP_E_HIGH1:  e_in   = 1'b1;
               STEP_NIB_HIGH: nib_in = cur_byte[7:4];
               STEP_E_LOW1:   e_in   = 1'b0;
               STEP_E_HIGH2:  e_in   = 1'b1;
               STEP_NIB_LOW:  nib_in = cur_byte[3:0];
               STEP_E_LOW2:   e_in   = 1'b0;
               default:       e_in   = e_ff;
            endcase
            out_rs_in   = rs_in;
            out_e_in    = e_in;
            out_nib_in  = nib_in;
            out_hold_in = HOLD_STEP_MS;
            idle_in     = 1'b0;
            if (cur_step == STEP_E_LOW2) begin
               step_in = STEP_RS;
               idx_in  = cur_idx + 1'b1;
            end else begin
               step_in = cur_step + 1'b1;
               idx_in  = cur_idx;
            end
            busy_in = !is_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idle_ff      <= 1'b0;
         step_ff      <= STEP_RS;
         idx_ff       <= 3'd0;
         rs_ff        <= 1'b0;
         e_ff         <= 1'b0;
         nib_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idle_ff      <= idle_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         rs_ff        <= rs_in;
         e_ff         <= e_in;
         nib_ff       <= nib_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      out_rs_ff   <= out_rs_in;
      out_e_ff    <= out_e_in;
      out_nib_ff  <= out_nib_in;
      out_hold_ff <= out_hold_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_reg_select  = out_rs_ff;
   assign rsp_enable_line = out_e_ff;
   assign rsp_data_nibble = out_nib_ff;
   assign rsp_hold_ms     = out_hold_ff;
   assign rsp_last_step   = out_last_ff;

endmodule

`default_nettype wire

FILE: sv/char_lcd_nibble_write_sequencer_unit.sv
// char_lcd_nibble_write_sequencer_unit: top level of the 4-bit lcd writer
// depends on lcdw_pkg, lcdw_front, lcdw_back
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | command, byte_value, row, column
//  rsp     | out       | rsp_valid/stall    | reg_select, enable_line, data_nibble,
//          |           |                    | hold_ms, last_step
//
// each byte or cursor transaction yields 7 pin states, one per cycle unless rsp stalls; init yields 36
// back to back transactions run without a gap, the next job starting straight from the queue head
// requests queue up to QUEUE_DEPTH deep while the sequencer is busy
// reset is synchronous and clears the queue, sequencer and line levels to zero
// a stalled response holds the sequencer; a full queue stalls requests
`default_nettype none

module char_lcd_nibble_write_sequencer_unit
   import lcdw_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_command,
   input  wire logic [7:0] req_byte_value,
   input  wire logic [1:0] req_row,
   input  wire logic [3:0] req_column,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_reg_select,
   output logic            rsp_enable_line,
   output logic [3:0]      rsp_data_nibble,
   output logic [4:0]      rsp_hold_ms,
   output logic            rsp_last_step
);

   queue_head_type head;
   logic           pop;

   // front: classify and queue
   lcdw_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_column     (req_column),
      .head           (head),
      .pop            (pop)
   );

   // back: pin-state sequencer
   lcdw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_enable_line (rsp_enable_line),
      .rsp_data_nibble (rsp_data_nibble),
      .rsp_hold_ms     (rsp_hold_ms),
      .rsp_last_step   (rsp_last_step)
   );

endmodule

`default_nettype wire

FILE: tb/tb_char_lcd_nibble_write_sequencer_unit.sv
// tb_char_lcd_nibble_write_sequencer_unit: self-checking bench for the 4-bit lcd writer
// predicts each pin state from the request stream, idles both channels at random
// depends on lcdw_pkg and char_lcd_nibble_write_sequencer_unit
`timescale 1ns / 1ps

module tb_char_lcd_nibble_write_sequencer_unit
   import lcdw_pkg::*;
();

   localparam int unsigned RESET_CYCLES = 11;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned LONG_HOLD_CYCLES = 200;

   // power-up instruction bytes and cursor row offsets
   localparam logic [7:0] POWER_UP_BYTES [5] = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h01};
   localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h10, 8'h50};

   typedef struct packed {
      logic       rs;
      logic       e;
      logic [3:0] nibble;
      logic [4:0] hold;
      logic       last;
   } pin_state_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_command = '0;
   logic [7:0] req_byte_value = '0;
   logic [1:0] req_row = '0;
   logic [3:0] req_column = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_reg_select;
   logic       rsp_enable_line;
   logic [3:0] rsp_data_nibble;
   logic [4:0] rsp_hold_ms;
   logic       rsp_last_step;

   // predicted line levels, mirror of the display pins
   logic       lcd_rs = 1'b0;
   logic       lcd_e = 1'b0;
   logic [3:0] lcd_nibble = '0;

   pin_state_type expected_pins[$];
   int unsigned error_count = 0;
   int unsigned pins_checked = 0;
   int unsigned ops_sent = 0;
   int unsigned power_ups_sent = 0;
   int unsigned cursor_moves_sent = 0;
   int unsigned req_held_cycles = 0;
   int unsigned long_hold_request = 0;
   bit          steady_flow = 1'b0;

   char_lcd_nibble_write_sequencer_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_byte_value  (req_byte_value),
      .req_row         (req_row),
      .req_column      (req_column),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_enable_line (rsp_enable_line),
      .rsp_data_nibble (rsp_data_nibble),
      .rsp_hold_ms     (rsp_hold_ms),
      .rsp_last_step   (rsp_last_step)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return 0;
      if (r < 97) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one predicted pin state from the current line levels
   function automatic void push_pin_state(input logic [4:0] hold);
      pin_state_type p;
      p.rs = lcd_rs;
      p.e = lcd_e;
      p.nibble = lcd_nibble;
      p.hold = hold;
      p.last = 1'b0;
      expected_pins.push_back(p);
   endfunction

   // seven pin states of one byte on the 4-bit bus
   function automatic void predict_byte_write(input logic rs, input logic [7:0] value);
      lcd_rs = rs;
      push_pin_state(HOLD_STEP_MS);
      lcd_e = 1'b1;
      push_pin_state(HOLD_STEP_MS);
      lcd_nibble = value[7:4];
      push_pin_state(HOLD_STEP_MS);
      lcd_e = 1'b0;
      push_pin_state(HOLD_STEP_MS);
      lcd_e = 1'b1;
      push_pin_state(HOLD_STEP_MS);
      lcd_nibble = value[3:0];
      push_pin_state(HOLD_STEP_MS);
      lcd_e = 1'b0;
      push_pin_state(HOLD_STEP_MS);
   endfunction

   // full pin sequence of one accepted transaction
   function automatic void predict_operation(input command_type cmd, input logic [7:0] value,
                                             input logic [1:0] row, input logic [3:0] column);
      logic [7:0] address;
      case (cmd)
         CMD_INSTR: predict_byte_write(1'b0, value);
         CMD_DATA: predict_byte_write(1'b1, value);
         CMD_CURSOR: begin
            address = ROW_BASE[row] + {4'h0, column};
            predict_byte_write(1'b0, CURSOR_CMD_BIT | address);
            cursor_moves_sent++;
         end
         default: begin
            // idle state keeps the data lines, they clear just before the first byte
            lcd_rs = 1'b0;
            lcd_e = 1'b0;
            push_pin_state(HOLD_IDLE_MS);
            lcd_nibble = '0;
            for (int i = 0; i < 5; i++) predict_byte_write(1'b0, POWER_UP_BYTES[i]);
            power_ups_sent++;
         end
      endcase
      expected_pins[expected_pins.size() - 1].last = 1'b1;
      ops_sent++;
   endfunction

   function automatic void compare_field(input string name, input logic [4:0] want,
                                         input logic [4:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_pin_state();
      pin_state_type want;
      if (expected_pins.size() == 0) begin
         $error("pin state with nothing expected: rs=%0d e=%0d nibble=%0h hold=%0d last=%0d",
                rsp_reg_select, rsp_enable_line, rsp_data_nibble, rsp_hold_ms, rsp_last_step);
         error_count++;
         return;
      end
      want = expected_pins.pop_front();
      compare_field("reg_select", 5'(want.rs), 5'(rsp_reg_select));
      compare_field("enable_line", 5'(want.e), 5'(rsp_enable_line));
      compare_field("data_nibble", 5'(want.nibble), 5'(rsp_data_nibble));
      compare_field("hold_ms", want.hold, rsp_hold_ms);
      compare_field("last_step", 5'(want.last), 5'(rsp_last_step));
      pins_checked++;
   endfunction

   // response side: check each pin state, then choose the stall for the next edge
   initial begin : pin_state_monitor
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_pin_state();
         if (long_hold_request != 0) begin
            stall_left = long_hold_request;
            long_hold_request = 0;
         end
         if (stall_left == 0 && !steady_flow) stall_left = pick_gap();
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one request and wait for the handshake, valid stays high if no gap follows
   task automatic send_op(input command_type cmd, input logic [7:0] value,
                          input logic [1:0] row, input logic [3:0] column);
      int unsigned gap;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_byte_value <= value;
      req_row <= row;
      req_column <= column;
      do begin
         @(posedge clock);
         if (req_stall) req_held_cycles++;
      end while (req_stall);
      predict_operation(cmd, value, row, column);
      gap = steady_flow ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and let every expected pin state come out
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_pins.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // power-up, then byte extremes for both register selects
   task automatic test_byte_writes();
      send_op(CMD_INIT, 8'h00, 2'd0, 4'd0);
      send_op(CMD_INSTR, 8'h00, 2'd3, 4'd15);
      send_op(CMD_INSTR, 8'hFF, 2'd0, 4'd0);
      send_op(CMD_INSTR, 8'hA5, 2'd1, 4'd10);
      send_op(CMD_INSTR, 8'h5A, 2'd2, 4'd5);
      send_op(CMD_DATA, 8'h00, 2'd3, 4'd15);
      send_op(CMD_DATA, 8'hFF, 2'd0, 4'd0);
      send_op(CMD_DATA, 8'h3C, 2'd2, 4'd9);
   endtask

   // corner columns on every row
   task automatic test_cursor_corners();
      for (int r = 0; r < 4; r++) begin
         send_op(CMD_CURSOR, 8'hFF, 2'(r), 4'd0);
         send_op(CMD_CURSOR, 8'h00, 2'(r), 4'd15);
      end
   endtask

   // power-up after a byte that leaves the data lines high, ignored fields set
   task automatic test_power_up_idle_lines();
      send_op(CMD_DATA, 8'h9F, 2'd0, 4'd0);
      send_op(CMD_INIT, 8'hFF, 2'd3, 4'd15);
   endtask

   // response side holds off for a long stretch while requests keep coming
   task automatic test_back_pressure();
      steady_flow = 1'b1;
      long_hold_request = LONG_HOLD_CYCLES;
      for (int i = 0; i < 12; i++) begin
         send_op(command_type'($urandom_range(0, 2)), 8'($urandom), 2'($urandom),
                 4'($urandom));
      end
      steady_flow = 1'b0;
   endtask

   // random mix, with stretches of back to back traffic
   task automatic test_random_traffic(input int unsigned count);
      command_type cmd;
      int unsigned r;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 40) steady_flow = 1'b1;
         if (i % 60 == 0) steady_flow = 1'b0;
         r = $urandom_range(0, 99);
         if (r < 35) cmd = CMD_DATA;
         else if (r < 65) cmd = CMD_INSTR;
         else if (r < 93) cmd = CMD_CURSOR;
         else cmd = CMD_INIT;
         send_op(cmd, 8'($urandom), 2'($urandom), 4'($urandom));
      end
      steady_flow = 1'b0;
   endtask

   // test sequence
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_byte_writes();
      test_cursor_corners();
      test_power_up_idle_lines();
      wait_for_drain();
      test_back_pressure();
      wait_for_drain();
      test_random_traffic(250);
      wait_for_drain();
      $display("ran %0d transactions: %0d power-up sequences, %0d cursor moves",
               ops_sent, power_ups_sent, cursor_moves_sent);
      $display("checked %0d pin states, requests held back for %0d cycles",
               pins_checked, req_held_cycles);
      if (error_count == 0 && expected_pins.size() == 0) begin
         $display("** char_lcd_nibble_write_sequencer_unit: PASSED **");
      end else begin
         $display("** char_lcd_nibble_write_sequencer_unit: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(20_000_000);
      $display("timeout with %0d pin states still expected", expected_pins.size());
      $display("** char_lcd_nibble_write_sequencer_unit: FAILED **");
      $finish;
   end

endmodule
